[hdl/dasws_pkg.sv]
// Shared types, codes and constants for the DAC/ADC variable-write serializer.
// No dependencies; imported by every module of the block.
package dasws_pkg;

    localparam int DAC_CHANNELS_DEF = 8;
    localparam int CODE_BITS_DEF    = 16;

    localparam int IDX_W   = 6;
    localparam int UV_W    = 24;
    localparam int MAG_W   = UV_W - 1;
    localparam int FRAME_W = 24;
    localparam int CODE_W  = 16;
    localparam int CNT_W   = 5;

    // variable indices
    localparam logic [IDX_W-1:0] IDX_ADC0     = 6'd0;
    localparam logic [IDX_W-1:0] IDX_ADC1     = 6'd1;
    localparam logic [IDX_W-1:0] IDX_DAC_BASE = 6'd8;
    localparam logic [IDX_W-1:0] IDX_POLARITY = 6'd33;

    // frame contents
    localparam logic [3:0] DAC_CMD       = 4'h3;
    localparam logic [3:0] ADC_MODE_ADDR = 4'h1;
    localparam logic [7:0] ADC_DATA0     = 8'h02;
    localparam logic [7:0] ADC_DATA1     = 8'h08;

    // bit counts loaded into the shifter
    localparam logic [CNT_W-1:0] CNT_ADC     = 5'd16;
    localparam logic [CNT_W-1:0] CNT_DAC     = 5'd24;
    localparam logic [CNT_W-1:0] CNT_POL     = 5'd1;
    // bits left when the first ADC frame ends (after its 8th bit)
    localparam logic [CNT_W-1:0] CNT_ADC_MID = 5'd9;

    // voltage scaling: code = round(2*FS*uV / 5e6)
    localparam logic [MAG_W-1:0] SCALE_DIV  = 23'd5000000;
    localparam logic [MAG_W-1:0] SCALE_HALF = 23'd2500000;

    typedef enum logic [1:0] {
        KIND_DAC = 2'd0,
        KIND_ADC = 2'd1,
        KIND_POL = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [FRAME_W-1:0] frame;   // left-justified, msb goes first
        logic [CNT_W-1:0]   count;
    } t_load;

    // DAC channel to chip address
    function automatic logic [3:0] chan_addr(input logic [2:0] ch);
        logic [3:0] a;
        unique case (ch)
            3'd0: a = 4'd4;
            3'd1: a = 4'd5;
            3'd2: a = 4'd2;
            3'd3: a = 4'd3;
            3'd4: a = 4'd1;
            3'd5: a = 4'd0;
            3'd6: a = 4'd7;
            3'd7: a = 4'd6;
            default: a = 4'd0;
        endcase
        return a;
    endfunction

endpackage

[hdl/dasws_code.sv]
// Voltage-to-code unit: bit-serial restoring division by 5e6 with rounding
// and saturation. Depends on dasws_pkg.
module dasws_code #(
    parameter int CODE_BITS = dasws_pkg::CODE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dasws_pkg::MAG_W-1:0]   i_uv,
    output logic                          o_done,
    output logic [dasws_pkg::CODE_W-1:0]  o_code
);
    import dasws_pkg::*;

    localparam int XW = CODE_BITS + UV_W;      // 2*FS*uV fits here
    localparam int CW = $clog2(XW + 1);

    logic [XW-1:0]        r_num;
    logic [MAG_W-1:0]     r_rem;
    logic [CODE_BITS-1:0] r_q;
    logic                 r_ovf;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_fin;

    logic [XW-1:0]        num_init;
    logic [MAG_W:0]       trial;
    logic [MAG_W:0]       trial_sub;
    logic                 ge;
    logic                 rnd;
    logic [CODE_BITS:0]   sum;
    logic [CODE_BITS-1:0] code_c;

    // 2*FS*uV = (uV << (C+1)) - (uV << 1)
    assign num_init  = (XW'(i_uv) << (CODE_BITS + 1)) - (XW'(i_uv) << 1);

    assign trial     = {r_rem, r_num[XW-1]};
    assign ge        = trial >= {1'b0, SCALE_DIV};
    assign trial_sub = trial - {1'b0, SCALE_DIV};

    // round half up, then clamp to full scale
    assign rnd    = r_rem >= SCALE_HALF;
    assign sum    = {1'b0, r_q} + (CODE_BITS + 1)'(rnd);
    assign code_c = (r_ovf || sum[CODE_BITS]) ? {CODE_BITS{1'b1}} : sum[CODE_BITS-1:0];

    assign o_code = CODE_W'(code_c) << (CODE_W - CODE_BITS);
    assign o_done = r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_num  <= num_init;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= CW'(XW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
                r_num  <= r_num << 1;
                r_ovf  <= r_ovf | r_q[CODE_BITS-1];
                r_q    <= (r_q << 1) | CODE_BITS'(ge);
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

[hdl/dasws_shift.sv]
// Frame shifter and output stage: one serial bit per accepted result item.
// Depends on dasws_pkg.
module dasws_shift (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dasws_pkg::t_load  i_cmd,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [1:0]        o_kind,
    output logic              o_data_bit,
    output logic              o_frame_end,
    output logic              o_last
);
    import dasws_pkg::*;

    logic [FRAME_W-1:0] r_frame;
    logic [CNT_W-1:0]   r_count;
    t_kind              r_kind;

    assign o_valid     = r_count != '0;
    assign o_kind      = r_kind;
    assign o_data_bit  = r_frame[FRAME_W-1];
    assign o_last      = r_count == CNT_W'(1);
    assign o_frame_end = (r_kind != KIND_POL) &&
                         ((r_count == CNT_W'(1)) ||
                          (r_kind == KIND_ADC && r_count == CNT_ADC_MID));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_kind  <= KIND_DAC;
        end else if (i_load) begin
            r_frame <= i_cmd.frame;
            r_count <= i_cmd.count;
            r_kind  <= i_cmd.kind;
        end else if (o_valid && i_ready) begin
            r_frame <= r_frame << 1;
            r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

[hdl/dac_adc_spi_write_serializer_unit.sv]
// Top level of the DAC/ADC variable-write serializer: decode, polarity latch,
// sequencing. Depends on dasws_pkg, dasws_code and dasws_shift.
//
//  channel  handshake          fields
//  -------  -----------------  -------------------------------------------------
//  in       i_valid / o_ready  i_var_index, i_dac_microvolts, i_mode_bit
//  out      o_valid / i_ready  o_kind, o_data_bit, o_frame_end, o_polarity_pin,
//                              o_last
//
// One item at a time. ADC mode write: 16 result items, one per cycle while
// i_ready is high. Polarity write: one result item. DAC write: 24 result items,
// one per cycle while i_ready is high; a non-negative voltage first runs the
// bit-serial divider, whose rounded code then loads the frame. Other indices
// give no result, next item can follow in the next cycle.
// Reset is synchronous, active low, clears control state only; no clearing pass.
// A stalled output holds the current bit; o_ready is low until the last bit
// of the item has been taken.
module dac_adc_spi_write_serializer_unit #(
    parameter int DAC_CHANNELS = dasws_pkg::DAC_CHANNELS_DEF,
    parameter int CODE_BITS    = dasws_pkg::CODE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input item
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dasws_pkg::IDX_W-1:0]  i_var_index,
    input  logic signed [dasws_pkg::UV_W-1:0] i_dac_microvolts,
    input  logic                         i_mode_bit,
    // result item
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_kind,
    output logic                         o_data_bit,
    output logic                         o_frame_end,
    output logic                         o_polarity_pin,
    output logic                         o_last
);
    import dasws_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SEND
    } t_state;

    t_state     r_state;
    logic       r_polarity;
    logic [3:0] r_addr;      // mapped DAC address, held while dividing

    logic              in_acc;
    logic              is_adc;
    logic              is_dac;
    logic              is_pol;
    logic              uv_neg;
    logic              div_start;
    logic              div_done;
    logic [CODE_W-1:0] div_code;
    logic              load_en;
    t_load             load_cmd;
    logic              sh_last;

    assign in_acc = i_valid && o_ready;
    assign is_adc = (i_var_index == IDX_ADC0) || (i_var_index == IDX_ADC1);
    assign is_dac = (i_var_index >= IDX_DAC_BASE) &&
                    ({1'b0, i_var_index} < (IDX_W + 1)'(DAC_CHANNELS + 8));
    assign is_pol = i_var_index == IDX_POLARITY;
    assign uv_neg = i_dac_microvolts[UV_W-1];

    // negative voltage needs no division: code is zero
    assign div_start = in_acc && is_dac && !uv_neg;

    always_comb begin
        load_en  = 1'b0;
        load_cmd = '{kind: KIND_DAC, frame: '0, count: '0};
        priority if (in_acc && is_adc) begin
            load_en  = 1'b1;
            load_cmd = '{kind:  KIND_ADC,
                         frame: {4'h0, ADC_MODE_ADDR,
                                 (i_var_index == IDX_ADC0) ? ADC_DATA0 : ADC_DATA1, 8'h00},
                         count: CNT_ADC};
        end else if (in_acc && is_dac && uv_neg) begin
            load_en  = 1'b1;
            load_cmd = '{kind:  KIND_DAC,
                         frame: {DAC_CMD, chan_addr(i_var_index[2:0]), {CODE_W{1'b0}}},
                         count: CNT_DAC};
        end else if (in_acc && is_pol) begin
            load_en  = 1'b1;
            load_cmd = '{kind: KIND_POL, frame: '0, count: CNT_POL};
        end else if (div_done) begin
            load_en  = 1'b1;
            load_cmd = '{kind: KIND_DAC, frame: {DAC_CMD, r_addr, div_code}, count: CNT_DAC};
        end
    end

    assign o_ready        = r_state == ST_IDLE;
    assign o_polarity_pin = r_polarity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_polarity <= 1'b0;
        end else begin
            if (in_acc) begin
                r_addr <= chan_addr(i_var_index[2:0]);
                if (is_pol) begin
                    r_polarity <= i_mode_bit;
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (div_start) begin
                            r_state <= ST_CALC;
                        end else if (load_en) begin
                            r_state <= ST_SEND;
                        end
                    end
                end
                ST_CALC: begin
                    if (div_done) begin
                        r_state <= ST_SEND;
                    end
                end
                ST_SEND: begin
                    if (o_valid && i_ready && sh_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    dasws_code #(
        .CODE_BITS (CODE_BITS)
    ) u_code (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_uv    (i_dac_microvolts[MAG_W-1:0]),
        .o_done  (div_done),
        .o_code  (div_code)
    );

    dasws_shift u_shift (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load_en),
        .i_cmd       (load_cmd),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_data_bit  (o_data_bit),
        .o_frame_end (o_frame_end),
        .o_last      (sh_last)
    );

    assign o_last = sh_last;

endmodule

[hdl/dasws_check.sv]
// Port-level checker for the serializer top level, attached by bind below.
// Depends on dasws_pkg.
module dasws_check (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [1:0]                   o_kind,
    input logic                         o_data_bit,
    input logic                         o_frame_end,
    input logic                         o_polarity_pin,
    input logic                         o_last
);
    import dasws_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_data_bit) &&
                                $stable(o_frame_end) && $stable(o_last))
        else $error("stalled result item changed");

    // no new item is taken while results are pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while results pending");

    // polarity result is a single item with no serial content
    a_pol_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_POL |-> o_last && !o_data_bit && !o_frame_end)
        else $error("malformed polarity result");

    // the last bit of a serial frame always releases chip select
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && o_kind != KIND_POL |-> o_frame_end)
        else $error("last bit without frame end");

    // polarity pin moves only when an item is taken
    a_pol_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && o_ready) |=> $stable(o_polarity_pin))
        else $error("polarity pin changed without an item");

endmodule

bind dac_adc_spi_write_serializer_unit dasws_check u_check (.*);

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for dac_adc_spi_write_serializer_unit: queue-fed driver,
// clocked monitor, serial-bit predictor. Depends on dasws_pkg and the RTL only.
module testbench;
    import dasws_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 120;   // > divider latency plus one DAC frame
    localparam int RANDOM_ITEMS = 150;
    localparam int ADC_FRAME_BITS = 8;

    // chip address of each DAC channel
    localparam logic [3:0] CHAN_ADDR [8] = '{4'd4, 4'd5, 4'd2, 4'd3, 4'd1, 4'd0, 4'd7, 4'd6};

    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [UV_W-1:0]  uv;
        logic                    mode;
    } t_var_write;

    typedef struct {
        t_kind kind;
        logic  data;
        logic  fend;
        logic  pol;
        logic  last;
    } t_serial_bit;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [IDX_W-1:0]          i_var_index;
    logic signed [UV_W-1:0]    i_dac_microvolts;
    logic                      i_mode_bit;
    logic                      o_valid;
    logic                      i_ready;
    logic [1:0]                o_kind;
    logic                      o_data_bit;
    logic                      o_frame_end;
    logic                      o_polarity_pin;
    logic                      o_last;

    t_var_write  pending_writes[$];
    t_serial_bit expected_bits[$];

    logic pol_level;        // predicted polarity switch level
    int   err_count;
    int   cycle_count;

    // handshake state: the taken flags are set at the rising edge, consumed at the falling edge
    bit   in_taken;
    bit   out_taken;
    bit   sending;
    int   in_gap;
    int   out_stall;
    bit   idle_in;
    bit   idle_out;

    dac_adc_spi_write_serializer_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_var_index      (i_var_index),
        .i_dac_microvolts (i_dac_microvolts),
        .i_mode_bit       (i_mode_bit),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_data_bit       (o_data_bit),
        .o_frame_end      (o_frame_end),
        .o_polarity_pin   (o_polarity_pin),
        .o_last           (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // round-half-up of uV * FS / 2.5 V, clamped to 0..FS, left-justified
    function automatic logic [CODE_W-1:0] microvolts_to_code(input logic signed [UV_W-1:0] uv);
        longint unsigned fs;
        longint unsigned q;
        fs = (64'd1 << CODE_BITS_DEF) - 64'd1;
        if (uv < 0)
            return '0;
        q = (64'(uv) * fs * 64'd2 + 64'(SCALE_HALF)) / 64'(SCALE_DIV);
        if (q > fs)
            q = fs;
        return CODE_W'(q << (CODE_W - CODE_BITS_DEF));
    endfunction

    function automatic bit is_dac_index(input logic [IDX_W-1:0] idx);
        return idx >= IDX_DAC_BASE && int'(idx) < int'(IDX_DAC_BASE) + DAC_CHANNELS_DEF;
    endfunction

    function automatic bit is_live_index(input logic [IDX_W-1:0] idx);
        return idx == IDX_ADC0 || idx == IDX_ADC1 || idx == IDX_POLARITY || is_dac_index(idx);
    endfunction

    // queue the low nbits of frame msb first; chip select drops after bits end_a/end_b
    task automatic queue_frame_bits(input t_kind kind, input logic [FRAME_W-1:0] frame,
                                    input int nbits, input int end_a, input int end_b);
        t_serial_bit b;
        for (int pos = 1; pos <= nbits; pos++) begin
            b.kind = kind;
            b.data = frame[nbits - pos];
            b.fend = (pos == end_a || pos == end_b);
            b.pol  = pol_level;
            b.last = (pos == nbits);
            expected_bits.push_back(b);
        end
    endtask

    task automatic predict_write_bits(input t_var_write w);
        logic [FRAME_W-1:0] frame;
        logic [2:0]         ch;
        t_serial_bit        b;
        if (w.idx == IDX_ADC0 || w.idx == IDX_ADC1) begin
            // mode register address frame, then the data byte frame
            frame = {8'h00, 4'h0, ADC_MODE_ADDR, (w.idx == IDX_ADC0) ? ADC_DATA0 : ADC_DATA1};
            queue_frame_bits(KIND_ADC, frame, int'(CNT_ADC), ADC_FRAME_BITS, int'(CNT_ADC));
        end else if (is_dac_index(w.idx)) begin
            ch    = 3'(w.idx - IDX_DAC_BASE);
            frame = {DAC_CMD, CHAN_ADDR[ch], microvolts_to_code(w.uv)};
            queue_frame_bits(KIND_DAC, frame, int'(CNT_DAC), int'(CNT_DAC), int'(CNT_DAC));
        end else if (w.idx == IDX_POLARITY) begin
            pol_level = w.mode;
            b.kind = KIND_POL;
            b.data = 1'b0;
            b.fend = 1'b0;
            b.pol  = pol_level;
            b.last = 1'b1;
            expected_bits.push_back(b);
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d want %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_write(input logic [IDX_W-1:0] idx, input int uv, input logic mode);
        t_var_write w;
        w.idx  = idx;
        w.uv   = UV_W'(uv);
        w.mode = mode;
        pending_writes.push_back(w);
    endtask

    function automatic int random_microvolts();
        longint m;
        case ($urandom_range(0, 4))
            0: return int'($urandom_range(0, 10000000)) - 5000000;
            1: return int'($urandom_range(0, 2600000));
            2: begin
                // land on a rounding step of the code
                m = longint'($urandom_range(1, 65535));
                return int'((m * 5000000 - 2500000) / 131070) + int'($urandom_range(0, 2)) - 1;
            end
            3: return -int'($urandom_range(1, 1000));
            default: return int'($urandom_range(2499000, 2501000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: one variable write at a time, random gap before each
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_var_write w;
        if (i_rst_n) begin
            if (in_taken) begin
                in_taken = 1'b0;
                sending  = 1'b0;
                if ($urandom_range(0, 14) == 0)
                    idle_in = !idle_in;
                in_gap = idle_in ? $urandom_range(0, 5) : 0;
            end
            if (!sending && pending_writes.size() > 0) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else begin
                    w = pending_writes.pop_front();
                    i_var_index      <= w.idx;
                    i_dac_microvolts <= w.uv;
                    i_mode_bit       <= w.mode;
                    sending = 1'b1;
                end
            end
            i_valid <= sending;
        end
    end

    // result side back-pressure: random stall after each taken bit
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                out_taken = 1'b0;
                if ($urandom_range(0, 19) == 0)
                    idle_out = !idle_out;
                out_stall = idle_out ? $urandom_range(0, 5) : 0;
            end
            if (out_stall > 0) begin
                out_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input accept, then check any result taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_var_write  w;
        t_serial_bit want;
        cycle_count++;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                w.idx  = i_var_index;
                w.uv   = i_dac_microvolts;
                w.mode = i_mode_bit;
                predict_write_bits(w);
                in_taken = 1'b1;
            end
            if (o_valid && i_ready) begin
                out_taken = 1'b1;
                if (expected_bits.size() == 0) begin
                    flag_mismatch("result with none pending, kind", int'(o_kind), -1);
                end else begin
                    want = expected_bits.pop_front();
                    if (o_kind !== want.kind)
                        flag_mismatch("kind", int'(o_kind), int'(want.kind));
                    if (o_data_bit !== want.data)
                        flag_mismatch("data_bit", int'(o_data_bit), int'(want.data));
                    if (o_frame_end !== want.fend)
                        flag_mismatch("frame_end", int'(o_frame_end), int'(want.fend));
                    if (o_polarity_pin !== want.pol)
                        flag_mismatch("polarity_pin", int'(o_polarity_pin), int'(want.pol));
                    if (o_last !== want.last)
                        flag_mismatch("last", int'(o_last), int'(want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed items, random items, drain, verdict
    // ------------------------------------------------------------------
    initial begin
        int r;
        logic [IDX_W-1:0] idx;

        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_ready          = 1'b0;
        i_var_index      = '0;
        i_dac_microvolts = '0;
        i_mode_bit       = 1'b0;
        pol_level        = 1'b0;
        err_count        = 0;
        cycle_count      = 0;
        idle_in          = 1'b1;
        idle_out         = 1'b1;
        in_gap           = 0;
        out_stall        = 0;

        // directed: both ADC modes, polarity both ways, code extremes and
        // rounding edges, every DAC channel, indices just outside the ranges
        add_write(IDX_ADC0, 0, 1'b0);
        add_write(IDX_ADC1, -5000000, 1'b1);
        add_write(IDX_POLARITY, 0, 1'b1);
        add_write(IDX_DAC_BASE, 0, 1'b0);
        add_write(IDX_W'(IDX_DAC_BASE + 1), 5000000, 1'b0);
        add_write(IDX_W'(IDX_DAC_BASE + 2), -5000000, 1'b1);
        add_write(IDX_W'(IDX_DAC_BASE + 3), 2500000, 1'b0);
        add_write(IDX_W'(IDX_DAC_BASE + 4), 2499981, 1'b0);
        add_write(IDX_W'(IDX_DAC_BASE + 5), 19, 1'b0);
        add_write(IDX_W'(IDX_DAC_BASE + 6), 20, 1'b1);
        add_write(IDX_W'(IDX_DAC_BASE + 7), -1, 1'b0);
        add_write(IDX_W'(IDX_DAC_BASE + 7), 2500001, 1'b0);
        add_write(IDX_W'(IDX_ADC1 + 1), 1234567, 1'b1);
        add_write(IDX_W'(IDX_DAC_BASE - 1), 4000000, 1'b1);
        add_write(IDX_W'(IDX_DAC_BASE + DAC_CHANNELS_DEF), 1000000, 1'b1);
        add_write(IDX_W'(IDX_POLARITY + 1), 0, 1'b0);
        add_write('1, -4194304, 1'b1);
        add_write(IDX_ADC0, 0, 1'b0);
        add_write(IDX_POLARITY, 0, 1'b0);
        add_write(IDX_ADC1, 0, 1'b1);
        add_write(IDX_DAC_BASE, 1250000, 1'b0);

        // random: live indices dominate, ignored ones mixed in as noise
        repeat (RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                idx = $urandom_range(0, 1) ? IDX_ADC1 : IDX_ADC0;
            end else if (r < 70) begin
                idx = IDX_DAC_BASE + IDX_W'($urandom_range(0, DAC_CHANNELS_DEF - 1));
            end else if (r < 85) begin
                idx = IDX_POLARITY;
            end else begin
                idx = IDX_W'($urandom_range(0, 63));
                while (is_live_index(idx))
                    idx = IDX_W'($urandom_range(0, 63));
            end
            add_write(idx, random_microvolts(), 1'($urandom_range(0, 1)));
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(pending_writes.size() == 0 && !sending && expected_bits.size() == 0)
               && cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);

        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (expected_bits.size() != 0)
                flag_mismatch("results never delivered", 0, expected_bits.size());
            if (err_count == 0)
                $display("TB_OK");
            else
                $display("TB_ERROR");
        end
        $finish;
    end

endmodule
